@@ rtl/sorted_key_table_search_delete_core_macros.svh @@
// assertion macros used by the checker file
`ifndef SORTED_KEY_TABLE_SEARCH_DELETE_CORE_MACROS_SVH
`define SORTED_KEY_TABLE_SEARCH_DELETE_CORE_MACROS_SVH

// property checked on every rising edge while out of reset
`define SKT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// a stalled signal must hold its value into the next cycle
`define SKT_ASSERT_HOLD(label, cond, sig, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(cond) |=> $stable(sig)) else $error(msg);

`endif

@@ rtl/skt_pkg.sv @@
`timescale 1ns / 1ps

package skt_pkg;

	localparam int DEPTH     = 256;
	localparam int KEY_BITS  = 20;
	localparam int IDX_BITS  = $clog2(DEPTH);
	localparam int CNT_BITS  = IDX_BITS + 1;
	localparam int IN_BYTES  = (KEY_BITS + 7) / 8;
	localparam int OUT_BITS  = IDX_BITS + CNT_BITS;
	localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

	localparam logic ACT_APPEND = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	typedef enum logic [2:0] {
		STAT_APPENDED  = 3'd0,
		STAT_FULL      = 3'd1,
		STAT_REMOVED   = 3'd2,
		STAT_KEPT      = 3'd3,
		STAT_NOT_FOUND = 3'd4
	} status_t;

endpackage

@@ rtl/sorted_key_table_search_delete_core.sv @@
`timescale 1ns / 1ps

// channel    | direction | tdata                           | tuser
// s_axis     | in        | key                             | action, confirm
// m_axis     | out       | position, entries_after         | status
//
// every request is taken in idle and ends in the result state; a remove makes one read
// and one compare per search probe (at most log2(DEPTH)+1 probes), a miss ends on an empty range,
// and on delete the shift state moves each later entry down one place
// the key table sits in one ram; search compare and shift copy share its read port
// reset clears the entry count and control; table contents are not cleared
// a finished result waits in the output register while the next request runs
module sorted_key_table_search_delete_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [skt_pkg::IN_BYTES*8-1:0]     s_axis_tdata,  // key
	input  logic [1:0]                         s_axis_tuser,  // action, confirm
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [skt_pkg::OUT_BYTES*8-1:0]    m_axis_tdata,  // position, entries_after
	output logic [2:0]                         m_axis_tuser   // status
);

	localparam int IDX_BITS = skt_pkg::IDX_BITS;
	localparam int CNT_BITS = skt_pkg::CNT_BITS;
	localparam int KEY_BITS = skt_pkg::KEY_BITS;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SREAD  = 5'b00010,
		ST_SCMP   = 5'b00100,
		ST_SHIFT  = 5'b01000,
		ST_RESULT = 5'b10000
	} state_t;

	state_t                 state_q;
	logic [KEY_BITS-1:0]    key_q;
	logic                   confirm_q;
	logic [CNT_BITS-1:0]    count_q;
	logic [CNT_BITS-1:0]    lo_q;
	logic [CNT_BITS-1:0]    hi_q;      // exclusive upper bound
	logic [IDX_BITS-1:0]    mid_q;
	logic [CNT_BITS-1:0]    shift_idx_q;
	logic                   wr_pend_s1;
	logic [IDX_BITS-1:0]    wr_addr_s1;
	skt_pkg::status_t       res_status_q;
	logic [IDX_BITS-1:0]    res_pos_q;

	logic                   m_valid_q;
	skt_pkg::status_t       m_status_q;
	logic [IDX_BITS-1:0]    m_pos_q;
	logic [CNT_BITS-1:0]    m_count_q;

	logic [KEY_BITS-1:0]    mem [skt_pkg::DEPTH];
	logic [KEY_BITS-1:0]    rd_data_q;

	logic                   accept;
	logic                   is_full;
	logic [CNT_BITS:0]      mid_sum;
	logic [IDX_BITS-1:0]    mid;
	logic                   search_live;
	logic [CNT_BITS:0]      shift_next;
	logic                   shift_rd;
	logic                   rd_en;
	logic [IDX_BITS-1:0]    rd_addr;
	logic                   wr_en;
	logic [IDX_BITS-1:0]    wr_addr;
	logic [KEY_BITS-1:0]    wr_data;
	logic                   out_free;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign is_full       = (count_q == CNT_BITS'(skt_pkg::DEPTH));
	assign out_free      = !m_valid_q || m_axis_tready;

	// mid = floor((lo + hi - 1) / 2) with hi exclusive
	assign mid_sum     = {1'b0, lo_q} + {1'b0, hi_q} - (CNT_BITS+1)'(1);
	assign mid         = mid_sum[IDX_BITS:1];
	assign search_live = (lo_q < hi_q);

	assign shift_next = {1'b0, shift_idx_q} + (CNT_BITS+1)'(1);
	assign shift_rd   = (state_q == ST_SHIFT) && (shift_next < {1'b0, count_q});

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = mid;
		if (state_q == ST_SREAD) begin
			rd_en = search_live;
		end else if (state_q == ST_SHIFT) begin
			rd_en   = shift_rd;
			rd_addr = shift_next[IDX_BITS-1:0];
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[IDX_BITS-1:0];
		wr_data = s_axis_tdata[KEY_BITS-1:0];
		if (accept && s_axis_tuser[0] == skt_pkg::ACT_APPEND && !is_full) begin
			wr_en = 1'b1;
		end else if (state_q == ST_SHIFT && wr_pend_s1) begin
			wr_en   = 1'b1;
			wr_addr = wr_addr_s1;
			wr_data = rd_data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			wr_pend_s1  <= 1'b0;
			m_valid_q   <= 1'b0;
		end else begin
			wr_pend_s1 <= shift_rd;
			// the result state reloads the output register itself
			if (m_valid_q && m_axis_tready && state_q != ST_RESULT) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						key_q     <= s_axis_tdata[KEY_BITS-1:0];
						confirm_q <= s_axis_tuser[1];
						lo_q      <= '0;
						hi_q      <= count_q;
						if (s_axis_tuser[0] == skt_pkg::ACT_APPEND) begin
							state_q <= ST_RESULT;
							if (is_full) begin
								res_status_q <= skt_pkg::STAT_FULL;
								res_pos_q    <= '0;
							end else begin
								res_status_q <= skt_pkg::STAT_APPENDED;
								res_pos_q    <= count_q[IDX_BITS-1:0];
								count_q      <= count_q + CNT_BITS'(1);
							end
						end else begin
							state_q <= ST_SREAD;
						end
					end
				end
				ST_SREAD: begin
					if (search_live) begin
						mid_q   <= mid;
						state_q <= ST_SCMP;
					end else begin
						res_status_q <= skt_pkg::STAT_NOT_FOUND;
						res_pos_q    <= '0;
						state_q      <= ST_RESULT;
					end
				end
				ST_SCMP: begin
					if (rd_data_q < key_q) begin
						lo_q    <= {1'b0, mid_q} + CNT_BITS'(1);
						state_q <= ST_SREAD;
					end else if (rd_data_q > key_q) begin
						hi_q    <= {1'b0, mid_q};
						state_q <= ST_SREAD;
					end else begin
						res_pos_q <= mid_q;
						if (confirm_q) begin
							res_status_q <= skt_pkg::STAT_REMOVED;
							shift_idx_q  <= {1'b0, mid_q};
							state_q      <= ST_SHIFT;
						end else begin
							res_status_q <= skt_pkg::STAT_KEPT;
							state_q      <= ST_RESULT;
						end
					end
				end
				ST_SHIFT: begin
					// read entry i+1 while the previous read, entry i, is written to entry i-1
					wr_addr_s1 <= shift_idx_q[IDX_BITS-1:0];
					if (shift_rd) begin
						shift_idx_q <= shift_next[CNT_BITS-1:0];
					end else if (!wr_pend_s1) begin
						count_q <= count_q - CNT_BITS'(1);
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						m_valid_q  <= 1'b1;
						m_status_q <= res_status_q;
						m_pos_q    <= res_pos_q;
						m_count_q  <= count_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_status_q;
	assign m_axis_tdata  = {(skt_pkg::OUT_BYTES*8-skt_pkg::OUT_BITS)'(0), m_count_q, m_pos_q};

endmodule

@@ rtl/skt_checker.sv @@
`timescale 1ns / 1ps

`include "sorted_key_table_search_delete_core_macros.svh"

module skt_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	input  logic [skt_pkg::OUT_BYTES*8-1:0]    m_axis_tdata,
	input  logic [2:0]                         m_axis_tuser
);

	localparam int IDX_BITS = skt_pkg::IDX_BITS;
	localparam int CNT_BITS = skt_pkg::CNT_BITS;

	logic [IDX_BITS-1:0] pos;
	logic [CNT_BITS-1:0] cnt;
	logic                no_pos;

	assign pos    = m_axis_tdata[IDX_BITS-1:0];
	assign cnt    = m_axis_tdata[IDX_BITS+CNT_BITS-1:IDX_BITS];
	assign no_pos = (m_axis_tuser == skt_pkg::STAT_FULL) ||
		(m_axis_tuser == skt_pkg::STAT_NOT_FOUND);

	`SKT_ASSERT_HOLD(a_result_hold, m_axis_tvalid && !m_axis_tready, {m_axis_tvalid, m_axis_tdata, m_axis_tuser}, "stalled result changed")

	`SKT_ASSERT(a_status_code, m_axis_tvalid |-> m_axis_tuser <= 3'(skt_pkg::STAT_NOT_FOUND), "bad status code")

	`SKT_ASSERT(a_no_position, m_axis_tvalid && no_pos |-> pos == '0, "position set without a hit")

	`SKT_ASSERT(a_count_range, m_axis_tvalid |-> cnt <= CNT_BITS'(skt_pkg::DEPTH), "entry count out of range")

	`SKT_ASSERT(a_append_count, m_axis_tvalid && m_axis_tuser == skt_pkg::STAT_APPENDED |-> cnt == {1'b0, pos} + CNT_BITS'(1), "append count mismatch")

endmodule

bind sorted_key_table_search_delete_core skt_checker u_skt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

@@ bench/sorted_key_table_search_delete_core_tb.sv @@
`timescale 1ns / 1ps

module sorted_key_table_search_delete_core_tb;
	import skt_pkg::*;

	localparam int MAX_KEY      = 999999;
	localparam int CYCLE_LIMIT  = 2000000;
	localparam int DRAIN_CYCLES = 300;
	localparam int MAX_REPORTS  = 40;

	typedef struct packed {
		status_t               status;
		logic [IDX_BITS-1:0]   position;
		logic [CNT_BITS-1:0]   entries_after;
	} outcome_t;

	logic                    clk           = 1'b0;
	logic                    arst_n        = 1'b0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [IN_BYTES*8-1:0]   s_axis_tdata  = '0;
	logic [1:0]              s_axis_tuser  = '0;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [OUT_BYTES*8-1:0]  m_axis_tdata;
	logic [2:0]              m_axis_tuser;

	// shadow copy of the key table and its fill level
	logic [KEY_BITS-1:0] table_keys [DEPTH];
	int unsigned         table_count    = 0;
	outcome_t            outcome_queue[$];

	int     errors         = 0;
	int     send_idle_pct  = 0;
	int     recv_stall_pct = 0;
	int     hold_len       = 0;
	int     hold_req       = 0;
	int     hold_seen      = 0;
	int     hold_left      = 0;
	longint cycles         = 0;

	sorted_key_table_search_delete_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic outcome_t table_action_outcome(input logic act,
			input logic [KEY_BITS-1:0] key, input logic conf);
		outcome_t res;
		int       lo;
		int       hi;
		int       mid;
		int       at;
		int       i;
		bit       found;
		res.status   = STAT_NOT_FOUND;
		res.position = '0;
		found        = 1'b0;
		at           = 0;
		if (act == ACT_APPEND) begin
			if (table_count >= DEPTH) begin
				res.status = STAT_FULL;
			end else begin
				table_keys[table_count] = key;
				res.position = IDX_BITS'(table_count);
				table_count++;
				res.status = STAT_APPENDED;
			end
		end else begin
			lo = 0;
			hi = int'(table_count) - 1;
			while (lo <= hi && !found) begin
				mid = (lo + hi) / 2;
				if (table_keys[mid] < key) begin
					lo = mid + 1;
				end else if (table_keys[mid] > key) begin
					hi = mid - 1;
				end else begin
					found = 1'b1;
					at    = mid;
				end
			end
			if (found) begin
				res.position = IDX_BITS'(at);
				if (conf) begin
					// close the gap left by the deleted entry
					for (i = at; i + 1 < int'(table_count); i++)
						table_keys[i] = table_keys[i + 1];
					table_count--;
					res.status = STAT_REMOVED;
				end else begin
					res.status = STAT_KEPT;
				end
			end
		end
		res.entries_after = CNT_BITS'(table_count);
		return res;
	endfunction

	task automatic send_request(input logic act, input logic [KEY_BITS-1:0] key,
			input logic conf);
		logic [IN_BYTES*8-1:0] word;
		word = '0;
		word[KEY_BITS-1:0] = key;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= word;
		s_axis_tuser  <= {conf, act};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		outcome_queue.push_back(table_action_outcome(act, key, conf));
	endtask

	// receiver side: random stalls, or a long counted hold when requested
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen     <= hold_req;
			hold_left     <= hold_len;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left     <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	task automatic flag_mismatch(input string field, input logic [31:0] want,
			input logic [31:0] got);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
	endtask

	always @(posedge clk) begin : check_result
		outcome_t want;
		outcome_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.status        = status_t'(m_axis_tuser);
			got.position      = m_axis_tdata[IDX_BITS-1:0];
			got.entries_after = m_axis_tdata[IDX_BITS +: CNT_BITS];
			if (outcome_queue.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected result, expected none, actual status %0d pos %0d count %0d",
						$time, m_axis_tuser, got.position, got.entries_after);
			end else begin
				want = outcome_queue.pop_front();
				if (m_axis_tuser !== want.status)
					flag_mismatch("status", want.status, m_axis_tuser);
				if (got.position !== want.position)
					flag_mismatch("position", want.position, got.position);
				if (got.entries_after !== want.entries_after)
					flag_mismatch("entries_after", want.entries_after, got.entries_after);
			end
		end
	end

	// mostly well-formed traffic: ascending appends and removes of held keys,
	// steered toward a fill level that moves every 50 requests
	task automatic run_random_mix(input int items, input int noise_pct);
		int          n;
		int          goal;
		int          base;
		int          step;
		int          pick;
		logic [KEY_BITS-1:0] key;
		bit          grow;
		goal = 0;
		for (n = 0; n < items; n++) begin
			if (n % 50 == 0)
				goal = $urandom_range(0, DEPTH);
			if ($urandom_range(0, 99) < noise_pct) begin
				send_request(1'($urandom_range(0, 1)), KEY_BITS'($urandom_range(0, MAX_KEY)),
					1'($urandom_range(0, 1)));
			end else begin
				if (table_count < goal)
					grow = ($urandom_range(0, 99) < 75);
				else
					grow = ($urandom_range(0, 99) < 25);
				if (grow) begin
					base = (table_count > 0) ? int'(table_keys[table_count - 1])
						: $urandom_range(0, 2000);
					step = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 7800);
					key  = KEY_BITS'((base + step > MAX_KEY) ? MAX_KEY : base + step);
					send_request(ACT_APPEND, key, 1'($urandom_range(0, 1)));
				end else begin
					pick = $urandom_range(0, 99);
					if (table_count > 0 && pick < 75) begin
						key = table_keys[$urandom_range(0, table_count - 1)];
					end else if (table_count > 0 && pick < 88) begin
						// near miss next to a held key
						base = int'(table_keys[$urandom_range(0, table_count - 1)]);
						base = base + ($urandom_range(0, 1) ? 1 : -1);
						key  = KEY_BITS'((base < 0) ? 0 : (base > MAX_KEY) ? MAX_KEY : base);
					end else begin
						key = KEY_BITS'($urandom_range(0, MAX_KEY));
					end
					send_request(ACT_REMOVE, key, $urandom_range(0, 99) < 80);
				end
			end
		end
	endtask

	task automatic test_directed();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		// remove on an empty table
		send_request(ACT_REMOVE, 0, 1'b1);
		send_request(ACT_REMOVE, KEY_BITS'(MAX_KEY), 1'b0);
		send_request(ACT_APPEND, 0, 1'b1);
		send_request(ACT_APPEND, 0, 1'b0);
		send_request(ACT_APPEND, 500000, 1'b0);
		send_request(ACT_APPEND, KEY_BITS'(MAX_KEY), 1'b0);
		send_request(ACT_APPEND, KEY_BITS'(MAX_KEY), 1'b1);
		send_request(ACT_REMOVE, 500000, 1'b0);
		send_request(ACT_REMOVE, 500000, 1'b1);
		send_request(ACT_REMOVE, 500000, 1'b1);
		send_request(ACT_REMOVE, 0, 1'b1);
		send_request(ACT_REMOVE, KEY_BITS'(MAX_KEY), 1'b1);
		send_request(ACT_REMOVE, 123, 1'b1);
		send_request(ACT_REMOVE, KEY_BITS'(MAX_KEY - 1), 1'b0);
		// out-of-order append: search misses a key that is held
		send_request(ACT_APPEND, 3, 1'b0);
		send_request(ACT_REMOVE, 3, 1'b1);
		send_request(ACT_REMOVE, KEY_BITS'(MAX_KEY), 1'b1);
		send_request(ACT_REMOVE, 3, 1'b0);
		send_request(ACT_REMOVE, 3, 1'b1);
		send_request(ACT_REMOVE, 0, 1'b1);
		send_request(ACT_REMOVE, 0, 1'b1);
	endtask

	task automatic test_fill_to_full();
		int base;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		while (table_count < DEPTH) begin
			base = int'(table_count) * 3900;
			send_request(ACT_APPEND, KEY_BITS'((base > MAX_KEY) ? MAX_KEY : base), 1'b0);
		end
		repeat (3) send_request(ACT_APPEND, KEY_BITS'(MAX_KEY), 1'b1);
		send_request(ACT_REMOVE, table_keys[DEPTH - 1], 1'b1);
		// longest shift: the first entry goes
		send_request(ACT_REMOVE, table_keys[0], 1'b1);
		send_request(ACT_REMOVE, table_keys[100], 1'b0);
		send_request(ACT_APPEND, KEY_BITS'(MAX_KEY), 1'b0);
		send_request(ACT_APPEND, KEY_BITS'(MAX_KEY), 1'b0);
		send_request(ACT_APPEND, KEY_BITS'(MAX_KEY), 1'b0);
	endtask

	task automatic test_random_no_idle();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		run_random_mix(200, 0);
	endtask

	task automatic test_random_sender_idle();
		send_idle_pct  = 51;
		recv_stall_pct = 0;
		run_random_mix(220, 0);
	endtask

	task automatic test_random_receiver_stall();
		send_idle_pct  = 0;
		recv_stall_pct = 51;
		run_random_mix(220, 0);
	endtask

	task automatic test_random_both_idle();
		send_idle_pct  = 9;
		recv_stall_pct = 9;
		run_random_mix(220, 0);
	endtask

	task automatic test_receiver_hold();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_len = 2000;
		hold_req++;
		run_random_mix(40, 0);
	endtask

	task automatic test_unordered_keys();
		send_idle_pct  = 9;
		recv_stall_pct = 9;
		run_random_mix(170, 30);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_fill_to_full();
		test_random_no_idle();
		test_random_sender_idle();
		test_random_receiver_stall();
		test_random_both_idle();
		test_receiver_hold();
		test_unordered_keys();

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (outcome_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/skt_pkg.sv
rtl/sorted_key_table_search_delete_core.sv
rtl/skt_checker.sv
bench/sorted_key_table_search_delete_core_tb.sv
